// ===== src/scatr_pkg.sv =====
// Shared types and constants for the smart-card answer-to-reset parser.
// No dependencies; imported by every module of the block.
package scatr_pkg;

    localparam int MAX_ATR_BYTES = 33;
    localparam int ATR_LEN_W     = 6;
    localparam int GROUP_W       = 5;
    localparam int OUT_DATA_W    = 56;

    localparam logic [1:0] STATUS_BUSY  = 2'd0;
    localparam logic [1:0] STATUS_DONE  = 2'd1;
    localparam logic [1:0] STATUS_ERROR = 2'd2;

    localparam logic [3:0] FI_DEFAULT    = 4'd1;
    localparam logic [3:0] DI_DEFAULT    = 4'd1;
    localparam logic [7:0] GUARD_DEFAULT = 8'd255;
    localparam logic [7:0] WI_DEFAULT    = 8'd10;
    localparam logic [7:0] IFSC_DEFAULT  = 8'd32;
    localparam logic [3:0] CWI_DEFAULT   = 4'd13;
    localparam logic [3:0] BWI_DEFAULT   = 4'd4;
    localparam logic [3:0] PROTO_T0      = 4'd0;
    localparam logic [3:0] PROTO_T1      = 4'd1;

    typedef enum logic [2:0] {
        KIND_TS      = 3'd0,
        KIND_T0      = 3'd1,
        KIND_TA      = 3'd2,
        KIND_TB      = 3'd3,
        KIND_TC      = 3'd4,
        KIND_TD      = 3'd5,
        KIND_HIST    = 3'd6,
        KIND_IGNORED = 3'd7
    } byte_kind_t;

    typedef struct packed {
        logic [1:0]           status;
        byte_kind_t           byte_kind;
        logic [3:0]           clock_rate_index;
        logic [3:0]           baud_divisor_index;
        logic [7:0]           extra_guard;
        logic [7:0]           wait_integer;
        logic [7:0]           info_field_size;
        logic [3:0]           char_wait_index;
        logic [3:0]           block_wait_index;
        logic                 use_crc;
        logic [3:0]           specific_protocol;
        logic [ATR_LEN_W-1:0] atr_length;
    } atr_result_t;

endpackage

// ===== src/scatr_decode.sv =====
// Per-byte ATR decode: parser state registers and the next-state logic.
// Depends on scatr_pkg.
module scatr_decode (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic [7:0]             atr_byte,
    input  logic                   first_byte,
    input  logic                   last_byte,
    output scatr_pkg::atr_result_t result
);
    import scatr_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_IFACE,
        PH_HIST,
        PH_TCK,
        PH_DONE,
        PH_ERR
    } phase_t;

    typedef struct packed {
        phase_t               phase;
        logic [3:0]           pending;
        logic [GROUP_W-1:0]   group;
        logic [3:0]           protocol;
        logic [3:0]           hist_left;
        logic                 check_needed;
        logic [ATR_LEN_W-1:0] count;
        logic [3:0]           fi;
        logic [3:0]           di;
        logic [7:0]           guard;
        logic [7:0]           wi;
        logic [7:0]           ifsc;
        logic [3:0]           cwi;
        logic [3:0]           bwi;
        logic                 crc;
        logic [3:0]           proto;
    } atr_state_t;

    localparam logic [ATR_LEN_W-1:0] MAX_LEN = ATR_LEN_W'(MAX_ATR_BYTES);
    localparam logic [GROUP_W-1:0]   GROUP_MAX = '1;

    atr_state_t state_reg;
    atr_state_t state_next;
    byte_kind_t kind;
    logic       consumed;
    logic       t1_group;
    logic [1:0] status;

    always_comb
    begin
        state_next = state_reg;
        kind       = KIND_IGNORED;
        consumed   = 1'b1;
        t1_group   = (state_reg.group >= GROUP_W'(3)) && (state_reg.protocol == PROTO_T1);

        if (first_byte)
        begin
            state_next.phase        = PH_IFACE;
            state_next.pending      = 4'b1000;
            state_next.group        = '0;
            state_next.protocol     = PROTO_T0;
            state_next.hist_left    = '0;
            state_next.check_needed = 1'b0;
            state_next.count        = ATR_LEN_W'(1);
            state_next.fi           = FI_DEFAULT;
            state_next.di           = DI_DEFAULT;
            state_next.guard        = GUARD_DEFAULT;
            state_next.wi           = WI_DEFAULT;
            state_next.ifsc         = IFSC_DEFAULT;
            state_next.cwi          = CWI_DEFAULT;
            state_next.bwi          = BWI_DEFAULT;
            state_next.crc          = 1'b0;
            state_next.proto        = PROTO_T0;
            kind                    = KIND_TS;
        end
        else
        begin
            unique case (state_reg.phase)
                PH_IFACE:
                begin
                    state_next.count = state_reg.count + ATR_LEN_W'(1);
                    if (state_reg.pending[0])
                    begin
                        state_next.pending[0] = 1'b0;
                        kind = KIND_TA;
                        if (state_reg.group == GROUP_W'(1))
                        begin
                            state_next.fi = atr_byte[7:4];
                            state_next.di = atr_byte[3:0];
                        end
                        else if (state_reg.group == GROUP_W'(2))
                            state_next.proto = atr_byte[3:0];
                        else if (t1_group)
                            state_next.ifsc = atr_byte;
                    end
                    else if (state_reg.pending[1])
                    begin
                        state_next.pending[1] = 1'b0;
                        kind = KIND_TB;
                        if (t1_group)
                        begin
                            state_next.cwi = atr_byte[3:0];
                            state_next.bwi = atr_byte[7:4];
                        end
                    end
                    else if (state_reg.pending[2])
                    begin
                        state_next.pending[2] = 1'b0;
                        kind = KIND_TC;
                        if (state_reg.group == GROUP_W'(1))
                            state_next.guard = atr_byte;
                        else if (state_reg.group == GROUP_W'(2))
                            state_next.wi = atr_byte;
                        else if (t1_group)
                            state_next.crc = atr_byte[0];
                    end
                    else
                    begin
                        if (state_reg.group == '0)
                        begin
                            kind = KIND_T0;
                            state_next.hist_left = atr_byte[3:0];
                        end
                        else
                        begin
                            kind = KIND_TD;
                            state_next.protocol = atr_byte[3:0];
                            if (atr_byte[3:0] != PROTO_T0)
                                state_next.check_needed = 1'b1;
                        end
                        state_next.pending = atr_byte[7:4];
                        if (state_reg.group != GROUP_MAX)
                            state_next.group = state_reg.group + GROUP_W'(1);
                    end
                    if (state_next.pending == '0)
                    begin
                        if (state_next.hist_left != '0)
                            state_next.phase = PH_HIST;
                        else if (state_next.check_needed)
                            state_next.phase = PH_TCK;
                        else
                            state_next.phase = PH_DONE;
                    end
                end
                PH_HIST:
                begin
                    state_next.count     = state_reg.count + ATR_LEN_W'(1);
                    kind                 = KIND_HIST;
                    state_next.hist_left = state_reg.hist_left - 4'd1;
                    if (state_next.hist_left != '0)
                        state_next.phase = PH_HIST;
                    else if (state_reg.check_needed)
                        state_next.phase = PH_TCK;
                    else
                        state_next.phase = PH_DONE;
                end
                PH_TCK:
                begin
                    state_next.count = state_reg.count + ATR_LEN_W'(1);
                    state_next.phase = PH_DONE;
                end
                default:
                    consumed = 1'b0;
            endcase
        end

        if (consumed && (state_next.phase != PH_DONE) &&
            (last_byte || (state_next.count >= MAX_LEN)))
            state_next.phase = PH_ERR;

        if (state_next.phase == PH_DONE)
            status = STATUS_DONE;
        else if (state_next.phase == PH_ERR)
            status = STATUS_ERROR;
        else
            status = STATUS_BUSY;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase        <= PH_IDLE;
            state_reg.pending      <= '0;
            state_reg.group        <= '0;
            state_reg.protocol     <= PROTO_T0;
            state_reg.hist_left    <= '0;
            state_reg.check_needed <= 1'b0;
            state_reg.count        <= '0;
            state_reg.fi           <= FI_DEFAULT;
            state_reg.di           <= DI_DEFAULT;
            state_reg.guard        <= GUARD_DEFAULT;
            state_reg.wi           <= WI_DEFAULT;
            state_reg.ifsc         <= IFSC_DEFAULT;
            state_reg.cwi          <= CWI_DEFAULT;
            state_reg.bwi          <= BWI_DEFAULT;
            state_reg.crc          <= 1'b0;
            state_reg.proto        <= PROTO_T0;
        end
        else if (step)
        begin
            state_reg <= state_next;
        end
    end

    assign result.status             = status;
    assign result.byte_kind          = kind;
    assign result.clock_rate_index   = state_next.fi;
    assign result.baud_divisor_index = state_next.di;
    assign result.extra_guard        = state_next.guard;
    assign result.wait_integer       = state_next.wi;
    assign result.info_field_size    = state_next.ifsc;
    assign result.char_wait_index    = state_next.cwi;
    assign result.block_wait_index   = state_next.bwi;
    assign result.use_crc            = state_next.crc;
    assign result.specific_protocol  = state_next.proto;
    assign result.atr_length         = state_next.count;

endmodule

// ===== src/smart_card_atr_parser_unit.sv =====
// Top level of the smart-card answer-to-reset parser: stream ports and pipeline.
// Depends on scatr_pkg and scatr_decode.
//
// Takes one ATR byte per transfer and returns one result transfer per byte, in
// order, with the decoded interface values after that byte. A byte passes an
// input register, one pass of per-byte decode logic, and a result register. One
// byte per cycle is sustained while the output is ready; the input side is ready
// when the input register is empty or its byte moves into the result register.
module smart_card_atr_parser_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] atr_byte
    input  logic        s_axis_tuser,   // [0] first_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] status, [5:2] clock_rate_index, [9:6] baud_divisor_index,
    // [17:10] extra_guard, [25:18] wait_integer, [33:26] info_field_size,
    // [37:34] char_wait_index, [41:38] block_wait_index, [42] use_crc,
    // [46:43] specific_protocol, [52:47] atr_length, [55:53] zero
    output logic [55:0] m_axis_tdata,
    output logic [2:0]  m_axis_tuser    // [2:0] byte_kind
);
    import scatr_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_first_reg;
    logic        in_last_reg;
    logic        out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [2:0]  out_kind_reg;
    logic        step;
    logic [OUT_DATA_W-1:0] out_data_next;
    atr_result_t result;

    assign step          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step;

    scatr_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .atr_byte   (in_byte_reg),
        .first_byte (in_first_reg),
        .last_byte  (in_last_reg),
        .result     (result)
    );

    assign out_data_next = {
        3'b000,
        result.atr_length,
        result.specific_protocol,
        result.use_crc,
        result.block_wait_index,
        result.char_wait_index,
        result.info_field_size,
        result.wait_integer,
        result.extra_guard,
        result.baud_divisor_index,
        result.clock_rate_index,
        result.status
    };

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (step)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg  <= s_axis_tdata;
            in_first_reg <= s_axis_tuser;
            in_last_reg  <= s_axis_tlast;
        end
        if (step)
        begin
            out_data_reg <= out_data_next;
            out_kind_reg <= result.byte_kind;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_kind_reg;

endmodule

// ===== src/scatr_checker.sv =====
// Port-level checks for the smart-card answer-to-reset parser, bound to the top.
// Depends on scatr_pkg and smart_card_atr_parser_unit.
module scatr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);
    import scatr_pkg::*;

    localparam logic [ATR_LEN_W-1:0] MAX_LEN = ATR_LEN_W'(MAX_ATR_BYTES);

    logic [1:0]           st;
    logic [ATR_LEN_W-1:0] len;
    logic                 parsed_kind;

    assign st  = m_axis_tdata[1:0];
    assign len = m_axis_tdata[52:47];
    assign parsed_kind = (m_axis_tuser != KIND_TS) && (m_axis_tuser != KIND_IGNORED);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result transfer dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result payload changed while stalled");

    a_ts_restart: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_TS) |->
            (len == ATR_LEN_W'(1)) && (st != STATUS_DONE))
        else $error("TS did not restart the byte count");

    a_parsed_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && parsed_kind |->
            (len >= ATR_LEN_W'(2)) && (len <= MAX_LEN) && (st != STATUS_BUSY || len < MAX_LEN))
        else $error("parsed byte outside ATR length bounds");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (st == STATUS_BUSY) || (st == STATUS_DONE) || (st == STATUS_ERROR))
        else $error("undefined status code");

endmodule

bind smart_card_atr_parser_unit scatr_checker u_scatr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
